[design/tss_pkg.sv]
// Shared types, constants and helpers for the three-stack shared store.
package tss_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int SIZE_W   = 5;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] STACK_NONE   = 2'd0;
  localparam logic [1:0] STACK_FIRST  = 2'd1;
  localparam logic [1:0] STACK_SECOND = 2'd2;
  localparam logic [1:0] STACK_THIRD  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BAD_ID = 2'd3
  } status_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic               shift_up;   // push: open a slot at pos
    logic               shift_down; // pop: close the slot at pos
    logic [CNT_W-1:0]   pos;
    logic [WORD_W-1:0]  word;
  } ctrl_t;

  // Reported size is the count masked to SIZE_W bits
  function automatic logic [SIZE_W-1:0] to_size(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+SIZE_W-1:0] wide;
    wide = {{SIZE_W{1'b0}}, cnt};
    return wide[SIZE_W-1:0];
  endfunction

endpackage

[design/tss_cell.sv]
// One row cell: holds a word; on a shift takes left, right or the pushed word.
module tss_cell
  import tss_pkg::*;
(
  input  logic              clk,
  input  ctrl_t             ctrl,
  input  logic [CNT_W-1:0]  index,
  input  logic [WORD_W-1:0] left,
  input  logic [WORD_W-1:0] right,
  output logic [WORD_W-1:0] q
);

  logic [WORD_W-1:0] q_next;

  always_comb begin
    q_next = q;
    if (ctrl.shift_up) begin
      if (index == ctrl.pos) begin
        q_next = ctrl.word;
      end else if (index > ctrl.pos) begin
        q_next = left;
      end
    end else if (ctrl.shift_down) begin
      if (index >= ctrl.pos) begin
        q_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

[design/tss_chain.sv]
// Row of CAPACITY cells, each wired to its neighbours; the end cells see zero on the open side.
module tss_chain
  import tss_pkg::*;
(
  input  logic              clk,
  input  ctrl_t             ctrl,
  output logic [WORD_W-1:0] cell_q [CAPACITY]
);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;

      if (g == 0) begin : g_lo
        assign left_w = '0;
      end else begin : g_lo_n
        assign left_w = cell_q[g-1];
      end

      if (g == CAPACITY - 1) begin : g_hi
        assign right_w = '0;
      end else begin : g_hi_n
        assign right_w = cell_q[g+1];
      end

      tss_cell u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .index (CNT_W'(g)),
        .left  (left_w),
        .right (right_w),
        .q     (cell_q[g])
      );
    end
  endgenerate

endmodule

[design/three_stacks_shared_store_core.sv]
// Top level: three stacks packed in one shared row of cells.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------
//   in      | in_valid  | in_stall  | action, stack_id, push_value
//   out     | out_valid | out_stall | status, pop_value, stack_size
//
// One transaction a cycle while in_stall is low: every cell shifts at once, so a push or pop
// finishes in the cycle it is taken and its result sits in the output
// register from the next cycle on.
// in_stall is high only while a result waits and out_stall holds it.
// Reset clears the three counts and the output valid; cell contents are
// left as they are, since only entries below the total count are read.
module three_stacks_shared_store_core
  import tss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     action,
  input  logic [1:0]               stack_id,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [WORD_W-1:0] pop_value,
  output logic [SIZE_W-1:0]        stack_size
);

  // Per-stack counts
  logic [CNT_W-1:0] count_first, count_second, count_third;
  logic [CNT_W-1:0] count_first_next, count_second_next, count_third_next;

  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  top_end;   // index just above the addressed top
  logic [CNT_W-1:0]  cnt_sel;
  logic [CNT_W-1:0]  cnt_after;
  logic [CNT_W-1:0]  top_idx;   // addressed top entry on pop
  logic              accept;
  logic              do_push, do_pop;
  status_t           res_status;
  logic [WORD_W-1:0] res_pop;
  ctrl_t             ctrl;
  logic [WORD_W-1:0] cell_q [CAPACITY];

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign total = count_first + count_second + count_third;

  always_comb begin
    top_end = count_first;
    cnt_sel = count_first;
    case (stack_id)
      STACK_SECOND: begin
        top_end = count_first + count_second;
        cnt_sel = count_second;
      end
      STACK_THIRD: begin
        top_end = total;
        cnt_sel = count_third;
      end
      default: begin
        top_end = count_first;
        cnt_sel = count_first;
      end
    endcase
  end

  assign top_idx = top_end - CNT_W'(1);

  // Decide the outcome; bad id is checked before full or empty
  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    res_status = ST_OK;
    if (stack_id == STACK_NONE) begin
      res_status = ST_BAD_ID;
    end else if (action == ACT_PUSH) begin
      if (total >= CNT_W'(CAPACITY)) begin
        res_status = ST_FULL;
      end else begin
        do_push = 1'b1;
      end
    end else begin
      if (cnt_sel == '0) begin
        res_status = ST_EMPTY;
      end else begin
        do_pop = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_after = cnt_sel;
    if (stack_id == STACK_NONE) begin
      cnt_after = '0;
    end else if (do_push) begin
      cnt_after = cnt_sel + CNT_W'(1);
    end else if (do_pop) begin
      cnt_after = cnt_sel - CNT_W'(1);
    end
  end

  // Popped word comes from the addressed top cell, just below top_end
  assign res_pop = do_pop ? cell_q[top_idx[IDX_W-1:0]] : '0;

  always_comb begin
    ctrl.shift_up   = accept & do_push;
    ctrl.shift_down = accept & do_pop;
    ctrl.pos        = do_push ? top_end : top_idx;
    ctrl.word       = push_value;
  end

  tss_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .cell_q (cell_q)
  );

  always_comb begin
    count_first_next  = count_first;
    count_second_next = count_second;
    count_third_next  = count_third;
    if (accept && (do_push || do_pop)) begin
      case (stack_id)
        STACK_FIRST:  count_first_next  = cnt_after;
        STACK_SECOND: count_second_next = cnt_after;
        STACK_THIRD:  count_third_next  = cnt_after;
        default:      count_first_next  = count_first;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_first  <= '0;
      count_second <= '0;
      count_third  <= '0;
    end else begin
      count_first  <= count_first_next;
      count_second <= count_second_next;
      count_third  <= count_third_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= res_status;
      pop_value  <= res_pop;
      stack_size <= to_size(cnt_after);
    end
  end

endmodule

[test/tb_three_stacks_shared_store_core.sv]
// Self-checking testbench for the three-stack shared store core.
`timescale 1ns / 100ps

typedef struct {
  tss_pkg::status_t                          status;
  logic signed [tss_pkg::WORD_W-1:0]         pop_value;
  logic [tss_pkg::SIZE_W-1:0]                stack_size;
} stack_reply_t;

// Shadow of the packed store plus the queue of replies still owed by the core
class stack_book;
  logic signed [tss_pkg::WORD_W-1:0] store [tss_pkg::CAPACITY];
  int                                depth [1:3];
  stack_reply_t                      owed [$];
  int errors, checked, full_seen, empty_seen, bad_seen, pushes_ok, pops_ok;

  function new();
    foreach (store[k]) store[k] = '0;
    foreach (depth[k]) depth[k] = 0;
    errors = 0; checked = 0; full_seen = 0; empty_seen = 0;
    bad_seen = 0; pushes_ok = 0; pops_ok = 0;
  endfunction

  function int pending();
    return owed.size();
  endfunction

  // Works out the reply for one accepted request and moves the shadow on
  function void note_request(logic act, logic [1:0] id,
                             logic signed [tss_pkg::WORD_W-1:0] word);
    stack_reply_t r;
    int total, slot, k;
    r.status = tss_pkg::ST_OK;
    r.pop_value = '0;
    r.stack_size = '0;
    if (id == tss_pkg::STACK_NONE) begin
      r.status = tss_pkg::ST_BAD_ID;
      bad_seen++;
    end else begin
      total = depth[1] + depth[2] + depth[3];
      slot = depth[1];
      if (id != tss_pkg::STACK_FIRST) slot += depth[2];
      if (id == tss_pkg::STACK_THIRD) slot += depth[3];
      if (act == tss_pkg::ACT_PUSH) begin
        if (total >= tss_pkg::CAPACITY) begin
          r.status = tss_pkg::ST_FULL;
          full_seen++;
        end else begin
          for (k = total; k > slot; k--) store[k] = store[k-1];
          store[slot] = word;
          depth[id]++;
          pushes_ok++;
        end
      end else if (depth[id] == 0) begin
        r.status = tss_pkg::ST_EMPTY;
        empty_seen++;
      end else begin
        slot--;
        r.pop_value = store[slot];
        for (k = slot; k + 1 < total; k++) store[k] = store[k+1];
        depth[id]--;
        pops_ok++;
      end
      r.stack_size = tss_pkg::SIZE_W'(depth[id]);
    end
    owed.push_back(r);
  endfunction

  task report(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  task check_result(logic [1:0] status, logic signed [tss_pkg::WORD_W-1:0] popped,
                    logic [tss_pkg::SIZE_W-1:0] size);
    stack_reply_t r;
    if (owed.size() == 0) begin
      report($sformatf("unexpected reply status=%0d pop=%0d size=%0d",
                       status, popped, size));
      return;
    end
    r = owed.pop_front();
    checked++;
    if (status !== r.status)
      report($sformatf("reply %0d status %0d, want %s", checked, status, r.status.name()));
    if (popped !== r.pop_value)
      report($sformatf("reply %0d pop_value %0d, want %0d", checked, popped, r.pop_value));
    if (size !== r.stack_size)
      report($sformatf("reply %0d stack_size %0d, want %0d", checked, size, r.stack_size));
  endtask
endclass

module tb_three_stacks_shared_store_core;
  import tss_pkg::*;

  localparam int PER_PHASE   = 188;     // random transactions per idling phase
  localparam int CYCLE_LIMIT = 150000;  // several times the slowest legal run
  localparam int HOLD_CYCLES = 80;      // long receiver hold-off

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     action = ACT_PUSH;
  logic [1:0]               stack_id = STACK_NONE;
  logic signed [WORD_W-1:0] push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] pop_value;
  logic [SIZE_W-1:0]        stack_size;

  stack_book book = new();

  int send_idle_pct = 0;   // chance the sender sits out a cycle
  int recv_stall_pct = 0;  // chance the receiver stalls a cycle
  int hold_left = 0;       // cycles of forced stall still to run
  int cycle_count = 0;

  three_stacks_shared_store_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .stack_id   (stack_id),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .pop_value  (pop_value),
    .stack_size (stack_size)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  // Updated on the falling edge so the core sees it settled at the rising edge.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: both channels sampled at the rising edge, before any register moves.
  // A reply accepted now always belongs to an earlier request, so order is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) book.check_result(status, pop_value, stack_size);
      if (in_valid && !in_stall) book.note_request(action, stack_id, push_value);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, book.pending());
      $display("three_stacks_shared_store_core verification failed");
      $finish;
    end
  end

  // Offers one transaction, after random idle cycles, and returns once it is taken.
  // Returns at a rising edge; the next change happens at the following falling edge.
  task automatic offer_request(logic act, logic [1:0] id, logic signed [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    action     <= act;
    stack_id   <= id;
    push_value <= word;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender goes quiet until every owed reply has come back
  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests; a bad stack id now and then
  task automatic random_request(int push_pct);
    logic [1:0] id;
    logic       act;
    id  = ($urandom_range(19) == 0) ? STACK_NONE : 2'($urandom_range(1, 3));
    act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
    offer_request(act, id, pick_word());
  endtask

  initial begin
    int phase, n, k, push_pct;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: bad id first, then pops on empty stacks
    offer_request(ACT_POP,  STACK_NONE, '0);
    offer_request(ACT_PUSH, STACK_NONE, 32'sh7FFF_FFFF);
    offer_request(ACT_POP,  STACK_FIRST,  '0);
    offer_request(ACT_POP,  STACK_SECOND, '0);
    offer_request(ACT_POP,  STACK_THIRD,  '0);
    // Extremes of the word, pushed out of order so later stacks get shifted
    offer_request(ACT_PUSH, STACK_THIRD,  32'sh8000_0000);
    offer_request(ACT_PUSH, STACK_FIRST,  32'sh7FFF_FFFF);
    offer_request(ACT_PUSH, STACK_SECOND, '1);
    offer_request(ACT_PUSH, STACK_FIRST,  '0);
    // Fill the store to capacity, spread over the three stacks
    for (k = 0; k < CAPACITY - 4; k++)
      offer_request(ACT_PUSH, 2'(1 + k % 3), $urandom);
    // Full store refuses pushes into any stack
    offer_request(ACT_PUSH, STACK_FIRST,  32'sh5555_5555);
    offer_request(ACT_PUSH, STACK_SECOND, 32'shAAAA_AAAA);
    offer_request(ACT_PUSH, STACK_THIRD,  '1);
    // Pop out of the middle stack: stack three slides down
    offer_request(ACT_POP,  STACK_SECOND, '0);
    drain_replies();

    // Random: four idling phases, push bias wandering so both full and empty recur
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      push_pct = 50;
      for (n = 0; n < PER_PHASE; n++) begin
        if (n % 30 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 15;
          endcase
        end
        // Long hold-off with the sender offering transactions at full rate, held back by in_stall
        if (phase == 0 && n == PER_PHASE / 2) hold_left = HOLD_CYCLES;
        random_request(push_pct);
      end
      drain_replies();
    end

    recv_stall_pct = 0;
    repeat (4) @(posedge clk);

    $display("%0d replies checked: %0d pushes and %0d pops done, %0d full, %0d empty,",
             book.checked, book.pushes_ok, book.pops_ok, book.full_seen, book.empty_seen);
    $display("%0d bad ids, over no idling, sender gaps, receiver stalls and both; %0d errors",
             book.bad_seen, book.errors);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("three_stacks_shared_store_core verification clean");
    end else begin
      $display("three_stacks_shared_store_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
design/tss_pkg.sv
design/tss_cell.sv
design/tss_chain.sv
design/three_stacks_shared_store_core.sv
test/tb_three_stacks_shared_store_core.sv
